[sv/fvcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fvcc_pkg;

    // Field and datapath widths.
    localparam int FLOW_W    = 16;
    localparam int INV_W     = 16;
    localparam int PROD_W    = 32;
    localparam int SQ_W      = 62;
    localparam int MAG2_W    = 63;
    localparam int RAD_W     = 64;
    localparam int CORDIC_W  = 35;
    localparam int ANGLE_W   = 16;
    localparam int ROOT_W    = 32;
    localparam int REM_W     = 34;
    localparam int AMP_W     = 17;
    localparam int MIX_W     = 21;
    localparam int SPAN_W    = 14;
    localparam int COLOR_W   = 8;

    // Number of cells in each chain.
    localparam int CORDIC_STEPS = 15;
    localparam int SQRT_STEPS   = ROOT_W;

    // Register reset value and special codes.
    localparam logic [INV_W-1:0]   INV_RESET    = 16'd4096;
    localparam logic [FLOW_W-1:0]  UNKNOWN_MARK = 16'd25600;
    localparam logic [COLOR_W-1:0] GREY_LEVEL   = 8'd128;
    localparam logic [COLOR_W-1:0] COLOR_MAX    = 8'd255;
    localparam logic [AMP_W-1:0]   AMP_MAX      = 17'd65536;

    // Angles in turns, 65536 is one full turn.
    localparam logic [ANGLE_W-1:0] ANGLE_ZERO          = 16'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_QUARTER       = 16'd16384;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF          = 16'd32768;
    localparam logic [ANGLE_W-1:0] ANGLE_THREE_QUARTER = 16'd49152;

    // Widths of the color segments.
    localparam logic [SPAN_W-1:0] SPAN_NARROW = 14'd4096;
    localparam logic [SPAN_W-1:0] SPAN_WIDE   = 14'd8192;

    // Color wheel segments, in order of the half angle.
    typedef enum logic [2:0] {
        SEG_RED_MAGENTA,
        SEG_MAGENTA_BLUE,
        SEG_BLUE_CYAN,
        SEG_CYAN_GREEN,
        SEG_GREEN_YELLOW,
        SEG_YELLOW_RED
    } t_segment;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    // Data handed along the angle chain.
    typedef struct packed {
        logic                       unknown;
        logic                       fixed;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ANGLE_W-1:0]         z;
        logic [MAG2_W-1:0]          mag2;
    } t_cordic_data;

    // Data handed along the square root chain.
    typedef struct packed {
        logic               unknown;
        logic [ANGLE_W-1:0] angle;
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } t_sqrt_data;

    // Rotation angle of each CORDIC step, round(atan(2^-i) / (2*pi) * 65536).
    function automatic logic [ANGLE_W-1:0] atan_turn(input int step);
        logic [ANGLE_W-1:0] turn;
        case (step)
            0:       turn = 16'd8192;
            1:       turn = 16'd4836;
            2:       turn = 16'd2555;
            3:       turn = 16'd1297;
            4:       turn = 16'd651;
            5:       turn = 16'd326;
            6:       turn = 16'd163;
            7:       turn = 16'd81;
            8:       turn = 16'd41;
            9:       turn = 16'd20;
            10:      turn = 16'd10;
            11:      turn = 16'd5;
            12:      turn = 16'd3;
            13:      turn = 16'd1;
            14:      turn = 16'd1;
            default: turn = 16'd0;
        endcase
        return turn;
    endfunction

    // Color stops along the half turn; the last one closes the wheel at red.
    function automatic t_rgb stop_color(input logic [2:0] stop);
        t_rgb color;
        case (stop)
            3'd0:    color = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            3'd1:    color = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
            3'd2:    color = '{red: 8'd64,  green: 8'd64,  blue: 8'd255};
            3'd3:    color = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
            3'd4:    color = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            3'd5:    color = '{red: 8'd255, green: 8'd255, blue: 8'd0};
            3'd6:    color = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            default: color = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
        endcase
        return color;
    endfunction

endpackage

`default_nettype wire

[sv/fvcc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fvcc_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [fvcc_pkg::FLOW_W-1:0] i_flow_x,
    input  wire logic signed [fvcc_pkg::FLOW_W-1:0] i_flow_y,
    input  wire logic [fvcc_pkg::INV_W-1:0]         i_inv,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output fvcc_pkg::t_cordic_data                  o_data
);

    // Stage valid bits and the ready chain that lets bubbles collapse.
    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4  = !r4_valid || i_ready;
    assign w_rdy3  = !r3_valid || w_rdy4;
    assign w_rdy2  = !r2_valid || w_rdy3;
    assign w_rdy1  = !r1_valid || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r4_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (w_rdy1) r1_valid <= i_valid;
            if (w_rdy2) r2_valid <= r1_valid;
            if (w_rdy3) r3_valid <= r2_valid;
            if (w_rdy4) r4_valid <= r3_valid;
        end
    end

    // Stage 1: capture the vector and flag the unknown marker.
    logic signed [fvcc_pkg::FLOW_W-1:0] r1_fx, r1_fy;
    logic                               r1_unknown;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_fx      <= i_flow_x;
            r1_fy      <= i_flow_y;
            r1_unknown <= ($unsigned(i_flow_x) == fvcc_pkg::UNKNOWN_MARK)
                       || ($unsigned(i_flow_y) == fvcc_pkg::UNKNOWN_MARK);
        end
    end

    // Stage 2: scale both components by the reciprocal of the maximum displacement.
    logic signed [fvcc_pkg::PROD_W:0]   w_px_full, w_py_full, w_inv_ext;
    logic signed [fvcc_pkg::PROD_W-1:0] r2_px, r2_py;
    logic                               r2_unknown;

    assign w_inv_ext = $signed({{(fvcc_pkg::PROD_W + 1 - fvcc_pkg::INV_W){1'b0}}, i_inv});
    assign w_px_full = (fvcc_pkg::PROD_W + 1)'(r1_fx) * w_inv_ext;
    assign w_py_full = (fvcc_pkg::PROD_W + 1)'(r1_fy) * w_inv_ext;

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r1_valid) begin
            r2_px      <= w_px_full[fvcc_pkg::PROD_W-1:0];
            r2_py      <= w_py_full[fvcc_pkg::PROD_W-1:0];
            r2_unknown <= r1_unknown;
        end
    end

    // Stage 3: squares of the magnitudes and the start point of the rotation.
    logic [fvcc_pkg::PROD_W-1:0] w_ax, w_ay;
    logic [fvcc_pkg::SQ_W-1:0]   w_sqx, w_sqy;
    logic [fvcc_pkg::SQ_W-1:0]   r3_sqx, r3_sqy;
    fvcc_pkg::t_cordic_data      n_start, r3_start;

    assign w_ax  = r2_px[fvcc_pkg::PROD_W-1] ? $unsigned(-r2_px) : $unsigned(r2_px);
    assign w_ay  = r2_py[fvcc_pkg::PROD_W-1] ? $unsigned(-r2_py) : $unsigned(r2_py);
    assign w_sqx = {31'd0, w_ax[fvcc_pkg::PROD_W-2:0]} * {31'd0, w_ax[fvcc_pkg::PROD_W-2:0]};
    assign w_sqy = {31'd0, w_ay[fvcc_pkg::PROD_W-2:0]} * {31'd0, w_ay[fvcc_pkg::PROD_W-2:0]};

    // Vectors on an axis get their angle here; others are folded into the right half plane.
    always_comb begin
        n_start         = '0;
        n_start.unknown = r2_unknown;
        n_start.x       = fvcc_pkg::CORDIC_W'(r2_px);
        n_start.y       = fvcc_pkg::CORDIC_W'(r2_py);
        n_start.z       = fvcc_pkg::ANGLE_ZERO;
        if (r2_px == '0) begin
            n_start.fixed = 1'b1;
            n_start.z     = r2_py[fvcc_pkg::PROD_W-1] ? fvcc_pkg::ANGLE_THREE_QUARTER
                                                      : fvcc_pkg::ANGLE_QUARTER;
        end else if (r2_py == '0) begin
            n_start.fixed = 1'b1;
            n_start.z     = r2_px[fvcc_pkg::PROD_W-1] ? fvcc_pkg::ANGLE_HALF
                                                      : fvcc_pkg::ANGLE_ZERO;
        end else if (r2_px[fvcc_pkg::PROD_W-1]) begin
            n_start.x = -fvcc_pkg::CORDIC_W'(r2_px);
            n_start.y = -fvcc_pkg::CORDIC_W'(r2_py);
            n_start.z = fvcc_pkg::ANGLE_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r2_valid) begin
            r3_sqx   <= w_sqx;
            r3_sqy   <= w_sqy;
            r3_start <= n_start;
        end
    end

    // Stage 4: squared magnitude joins the rotation data.
    fvcc_pkg::t_cordic_data n_data, r4_data;

    always_comb begin
        n_data      = r3_start;
        n_data.mag2 = {1'b0, r3_sqx} + {1'b0, r3_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r3_valid) begin
            r4_data <= n_data;
        end
    end

    assign o_data = r4_data;

endmodule

`default_nettype wire

[sv/fvcc_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module fvcc_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire fvcc_pkg::t_cordic_data i_data,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output fvcc_pkg::t_cordic_data      o_data
);

    logic                               r_valid;
    fvcc_pkg::t_cordic_data             n_data, r_data;
    logic signed [fvcc_pkg::CORDIC_W-1:0] w_x, w_y, w_xs, w_ys;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign w_x  = i_data.x;
    assign w_y  = i_data.y;
    assign w_xs = w_x >>> STEP;
    assign w_ys = w_y >>> STEP;

    // One vectoring rotation: turn the vector toward the x axis.
    always_comb begin
        n_data = i_data;
        if (!i_data.fixed) begin
            if (w_y > 0) begin
                n_data.x = w_x + w_ys;
                n_data.y = w_y - w_xs;
                n_data.z = i_data.z + fvcc_pkg::atan_turn(STEP);
            end else begin
                n_data.x = w_x - w_ys;
                n_data.y = w_y + w_xs;
                n_data.z = i_data.z - fvcc_pkg::atan_turn(STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

[sv/fvcc_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module fvcc_sqrt_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire fvcc_pkg::t_sqrt_data i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output fvcc_pkg::t_sqrt_data      o_data
);

    logic                           r_valid;
    fvcc_pkg::t_sqrt_data           n_data, r_data;
    logic [fvcc_pkg::REM_W+1:0]     w_rem_sh, w_trial;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Bring down the next two radicand bits and try the next root bit.
    assign w_rem_sh = {i_data.rem, i_data.rad[fvcc_pkg::RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, i_data.root, 2'b01};

    always_comb begin
        n_data     = i_data;
        n_data.rad = {i_data.rad[fvcc_pkg::RAD_W-3:0], 2'b00};
        if (w_rem_sh >= w_trial) begin
            n_data.rem  = fvcc_pkg::REM_W'(w_rem_sh - w_trial);
            n_data.root = {i_data.root[fvcc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = w_rem_sh[fvcc_pkg::REM_W-1:0];
            n_data.root = {i_data.root[fvcc_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

[sv/fvcc_color.sv]
`timescale 1ns / 1ps
`default_nettype none

module fvcc_color (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire fvcc_pkg::t_sqrt_data  i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [fvcc_pkg::COLOR_W-1:0] o_red,
    output logic [fvcc_pkg::COLOR_W-1:0] o_green,
    output logic [fvcc_pkg::COLOR_W-1:0] o_blue
);

    // Blend of two stops weighted by the distance into the segment.
    function automatic logic [fvcc_pkg::MIX_W-1:0] mix_level(
        input logic [fvcc_pkg::COLOR_W-1:0] c0,
        input logic [fvcc_pkg::COLOR_W-1:0] c1,
        input logic [fvcc_pkg::SPAN_W-1:0]  rest,
        input logic [fvcc_pkg::SPAN_W-1:0]  pos
    );
        logic [fvcc_pkg::MIX_W:0] sum;
        sum = (fvcc_pkg::MIX_W + 1)'(c0) * (fvcc_pkg::MIX_W + 1)'(rest)
            + (fvcc_pkg::MIX_W + 1)'(c1) * (fvcc_pkg::MIX_W + 1)'(pos);
        return sum[fvcc_pkg::MIX_W-1:0];
    endfunction

    // Scale a blend by the magnitude, drop the fraction and clamp.
    function automatic logic [fvcc_pkg::COLOR_W-1:0] shade(
        input logic [fvcc_pkg::AMP_W-1:0] amp,
        input logic [fvcc_pkg::MIX_W-1:0] mix,
        input logic                       wide
    );
        logic [fvcc_pkg::AMP_W+fvcc_pkg::MIX_W-1:0] prod;
        logic [9:0]                                  level;
        prod  = (fvcc_pkg::AMP_W + fvcc_pkg::MIX_W)'(amp)
              * (fvcc_pkg::AMP_W + fvcc_pkg::MIX_W)'(mix);
        level = wide ? 10'(prod[37:29]) : prod[37:28];
        return (level > 10'(fvcc_pkg::COLOR_MAX)) ? fvcc_pkg::COLOR_MAX
                                                  : level[fvcc_pkg::COLOR_W-1:0];
    endfunction

    logic r_m_valid, r_valid;
    logic w_m_ready;

    assign o_valid   = r_valid;
    assign o_ready   = w_m_ready;
    assign w_m_ready = !r_m_valid || i_ready || !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (w_m_ready) r_m_valid <= i_valid;
            if (!r_valid || i_ready) r_valid <= r_m_valid;
        end
    end

    // Mix stage: segment decode, magnitude clip and blend of the two stops.
    logic [14:0]                   w_h;
    fvcc_pkg::t_segment            w_seg;
    logic                          w_wide;
    logic [fvcc_pkg::SPAN_W-1:0]   w_dist, w_rest;
    logic [27:0]                   w_amp_full;
    logic [fvcc_pkg::AMP_W-1:0]    w_amp;
    fvcc_pkg::t_rgb                w_c0, w_c1;

    assign w_h = i_data.angle[fvcc_pkg::ANGLE_W-1:1];

    always_comb begin
        unique case (w_h[14:12]) inside
            3'd0:       w_seg = fvcc_pkg::SEG_RED_MAGENTA;
            3'd1:       w_seg = fvcc_pkg::SEG_MAGENTA_BLUE;
            3'd2:       w_seg = fvcc_pkg::SEG_BLUE_CYAN;
            3'd3:       w_seg = fvcc_pkg::SEG_CYAN_GREEN;
            3'd4, 3'd5: w_seg = fvcc_pkg::SEG_GREEN_YELLOW;
            default:    w_seg = fvcc_pkg::SEG_YELLOW_RED;
        endcase
    end

    assign w_wide = (w_seg == fvcc_pkg::SEG_GREEN_YELLOW) || (w_seg == fvcc_pkg::SEG_YELLOW_RED);
    assign w_dist = w_wide ? {1'b0, w_h[12:0]} : {2'b00, w_h[11:0]};
    assign w_rest = (w_wide ? fvcc_pkg::SPAN_WIDE : fvcc_pkg::SPAN_NARROW) - w_dist;
    assign w_c0   = fvcc_pkg::stop_color(3'(w_seg));
    assign w_c1   = fvcc_pkg::stop_color(3'(w_seg) + 3'd1);

    assign w_amp_full = i_data.root[fvcc_pkg::ROOT_W-1:4];
    assign w_amp      = (w_amp_full > 28'(fvcc_pkg::AMP_MAX)) ? fvcc_pkg::AMP_MAX
                                                              : w_amp_full[fvcc_pkg::AMP_W-1:0];

    logic                        r_m_unknown, r_m_wide;
    logic [fvcc_pkg::AMP_W-1:0]  r_m_amp;
    logic [fvcc_pkg::MIX_W-1:0]  r_m_red, r_m_green, r_m_blue;

    always_ff @(posedge i_clk) begin
        if (w_m_ready && i_valid) begin
            r_m_unknown <= i_data.unknown;
            r_m_wide    <= w_wide;
            r_m_amp     <= w_amp;
            r_m_red     <= mix_level(w_c0.red,   w_c1.red,   w_rest, w_dist);
            r_m_green   <= mix_level(w_c0.green, w_c1.green, w_rest, w_dist);
            r_m_blue    <= mix_level(w_c0.blue,  w_c1.blue,  w_rest, w_dist);
        end
    end

    // Output register: shaded color, or grey for an unknown vector.
    logic [fvcc_pkg::COLOR_W-1:0] n_red, n_green, n_blue;
    logic [fvcc_pkg::COLOR_W-1:0] r_red, r_green, r_blue;

    always_comb begin
        if (r_m_unknown) begin
            n_red   = fvcc_pkg::GREY_LEVEL;
            n_green = fvcc_pkg::GREY_LEVEL;
            n_blue  = fvcc_pkg::GREY_LEVEL;
        end else begin
            n_red   = shade(r_m_amp, r_m_red,   r_m_wide);
            n_green = shade(r_m_amp, r_m_green, r_m_wide);
            n_blue  = shade(r_m_amp, r_m_blue,  r_m_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_valid || i_ready) && r_m_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

[sv/flow_vector_color_coding_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Color coding of optical flow: each transfer on the input carries one flow vector
// (signed Q8.8), and each transfer on the output carries its color on the wheel,
// brightness set by the vector length after scaling by the reciprocal of the maximum
// displacement (unsigned Q4.12, reset 1.0); a component equal to 100.0 gives grey 128.
// The block takes one vector per clock when not stalled and consists of four front
// stages (capture, scaling multiply, squares, sum), a chain of 15 CORDIC cells for the
// angle, a chain of 32 square root cells that each settle one bit of the length, and
// two color stages ending in the output register. Every stage has its own valid bit,
// so empty stages fill while the output is stalled; the input stalls only when every
// stage holds a vector. The scale register is written through its own port, always
// ready, and should change only while no vector is in flight.
module flow_vector_color_coding_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [fvcc_pkg::FLOW_W-1:0] i_flow_x,
    input  wire logic signed [fvcc_pkg::FLOW_W-1:0] i_flow_y,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [fvcc_pkg::COLOR_W-1:0]            o_red,
    output logic [fvcc_pkg::COLOR_W-1:0]            o_green,
    output logic [fvcc_pkg::COLOR_W-1:0]            o_blue,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [fvcc_pkg::INV_W-1:0]         i_cfg_data
);

    // Scale register.
    logic [fvcc_pkg::INV_W-1:0] r_inv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= fvcc_pkg::INV_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_inv <= i_cfg_data;
        end
    end

    // Front stages feed the head of the angle chain.
    logic                          w_front_ready;
    logic [fvcc_pkg::CORDIC_STEPS:0] w_cordic_valid, w_cordic_ready;
    fvcc_pkg::t_cordic_data        w_cordic_data [fvcc_pkg::CORDIC_STEPS+1];

    assign o_in_stall = !w_front_ready;

    fvcc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (w_front_ready),
        .i_flow_x (i_flow_x),
        .i_flow_y (i_flow_y),
        .i_inv    (r_inv),
        .o_valid  (w_cordic_valid[0]),
        .i_ready  (w_cordic_ready[0]),
        .o_data   (w_cordic_data[0])
    );

    // Angle chain: one rotation per cell.
    genvar gi;
    generate
        for (gi = 0; gi < fvcc_pkg::CORDIC_STEPS; gi++) begin : g_cordic
            fvcc_cordic_cell #(
                .STEP (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_cordic_valid[gi]),
                .o_ready (w_cordic_ready[gi]),
                .i_data  (w_cordic_data[gi]),
                .o_valid (w_cordic_valid[gi+1]),
                .i_ready (w_cordic_ready[gi+1]),
                .o_data  (w_cordic_data[gi+1])
            );
        end
    endgenerate

    // The finished angle rides along the square root chain.
    logic [fvcc_pkg::SQRT_STEPS:0] w_sqrt_valid, w_sqrt_ready;
    fvcc_pkg::t_sqrt_data          w_sqrt_data [fvcc_pkg::SQRT_STEPS+1];

    assign w_sqrt_valid[0]                          = w_cordic_valid[fvcc_pkg::CORDIC_STEPS];
    assign w_cordic_ready[fvcc_pkg::CORDIC_STEPS]   = w_sqrt_ready[0];
    assign w_sqrt_data[0].unknown = w_cordic_data[fvcc_pkg::CORDIC_STEPS].unknown;
    assign w_sqrt_data[0].angle   = w_cordic_data[fvcc_pkg::CORDIC_STEPS].z;
    assign w_sqrt_data[0].rad     = {1'b0, w_cordic_data[fvcc_pkg::CORDIC_STEPS].mag2};
    assign w_sqrt_data[0].rem     = '0;
    assign w_sqrt_data[0].root    = '0;

    generate
        for (gi = 0; gi < fvcc_pkg::SQRT_STEPS; gi++) begin : g_sqrt
            fvcc_sqrt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_sqrt_valid[gi]),
                .o_ready (w_sqrt_ready[gi]),
                .i_data  (w_sqrt_data[gi]),
                .o_valid (w_sqrt_valid[gi+1]),
                .i_ready (w_sqrt_ready[gi+1]),
                .o_data  (w_sqrt_data[gi+1])
            );
        end
    endgenerate

    // Color stages and output register.
    fvcc_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sqrt_valid[fvcc_pkg::SQRT_STEPS]),
        .o_ready (w_sqrt_ready[fvcc_pkg::SQRT_STEPS]),
        .i_data  (w_sqrt_data[fvcc_pkg::SQRT_STEPS]),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    // The input may stall only when the chains are full behind a stalled result.
    a_stall_only_when_full : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&w_cordic_valid) && (&w_sqrt_valid) && o_out_valid && i_out_stall
    ) else $error("input stalled while the pipeline still had an empty stage");

    // A finished square root leaves a remainder no larger than twice the root.
    a_sqrt_remainder : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_valid[fvcc_pkg::SQRT_STEPS] |->
            (w_sqrt_data[fvcc_pkg::SQRT_STEPS].rem <=
             {1'b0, w_sqrt_data[fvcc_pkg::SQRT_STEPS].root, 1'b0})
    ) else $error("square root remainder out of range");

    // Rotations only lengthen x, so a folded vector keeps a positive x.
    a_cordic_x_positive : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cordic_valid[fvcc_pkg::CORDIC_STEPS] && !w_cordic_data[fvcc_pkg::CORDIC_STEPS].fixed
            |-> (w_cordic_data[fvcc_pkg::CORDIC_STEPS].x > 0)
    ) else $error("CORDIC x went non-positive");

endmodule

`default_nettype wire
